/* rtl/dq_pkg.sv */
`default_nettype none

package dq_pkg;

   localparam int DATA_W = 32;
   localparam int FUNC_W = 3;
   localparam int OCC_W  = 5;

   localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
   localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
   localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
   localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;

   // Front and back of an empty queue read as minus one.
   localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

   typedef struct packed {
      logic [FUNC_W-1:0]        func;
      logic signed [DATA_W-1:0] value;
   } dq_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] popped_value;
      logic                     underflow;
      logic                     overflow;
      logic signed [DATA_W-1:0] front_value;
      logic signed [DATA_W-1:0] back_value;
      logic [OCC_W-1:0]         occupancy;
   } dq_rsp_type;

   typedef struct packed {
      logic       load;
      dq_rsp_type rsp;
   } dq_load_type;

   typedef enum logic [0:0] {
      DQ_IDLE,
      DQ_READ
   } dq_state_type;

endpackage

`default_nettype wire

/* rtl/dq_ram.sv */
`default_nettype none

module dq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* rtl/dq_ctrl.sv */
`default_nettype none

module dq_ctrl #(
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire dq_pkg::dq_req_type       req_payload,
   input  wire logic                     out_free,
   output dq_pkg::dq_load_type           load,
   output logic                          ram_we,
   output logic [$clog2(DEPTH)-1:0]      ram_waddr,
   output logic [dq_pkg::DATA_W-1:0]     ram_wdata,
   output logic                          ram_re,
   output logic [$clog2(DEPTH)-1:0]      ram_raddr,
   input  wire logic [dq_pkg::DATA_W-1:0] ram_rdata
);

   import dq_pkg::*;

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

   dq_state_type             state_ff, state_in;
   logic [IW-1:0]            head_ff, head_in;
   logic [IW-1:0]            tail_ff, tail_in;
   logic [CW-1:0]            count_ff, count_in;
   logic signed [DATA_W-1:0] front_ff, front_in;
   logic signed [DATA_W-1:0] back_ff, back_in;
   logic                     pend_front_ff, pend_front_in;
   logic signed [DATA_W-1:0] pend_popped_ff, pend_popped_in;

   logic [IW-1:0]            head_inc, head_dec, tail_inc, tail_dec;
   logic                     full, empty, load_now;
   logic signed [DATA_W-1:0] popped;
   logic                     under, over;

   // The back index always equals head plus count minus one, with wrap.
   assign head_inc = (head_ff == LAST_IDX) ? '0 : IW'(head_ff + 1'b1);
   assign head_dec = (head_ff == '0) ? LAST_IDX : IW'(head_ff - 1'b1);
   assign tail_inc = (tail_ff == LAST_IDX) ? '0 : IW'(tail_ff + 1'b1);
   assign tail_dec = (tail_ff == '0) ? LAST_IDX : IW'(tail_ff - 1'b1);
   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);

   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      count_in       = count_ff;
      front_in       = front_ff;
      back_in        = back_ff;
      pend_front_in  = pend_front_ff;
      pend_popped_in = pend_popped_ff;
      ram_we         = 1'b0;
      ram_waddr      = tail_inc;
      ram_wdata      = req_payload.value;
      ram_re         = 1'b0;
      ram_raddr      = head_inc;
      load_now       = 1'b0;
      popped         = '0;
      under          = 1'b0;
      over           = 1'b0;
      req_ready      = (state_ff == DQ_IDLE) && out_free;

      case (state_ff)
         DQ_IDLE: begin
            if (req_valid && req_ready) begin
               load_now = 1'b1;
               case (req_payload.func)
                  FN_PUSH_FRONT, FN_PUSH_BACK: begin
                     if (full) begin
                        over = 1'b1;
                     end else begin
                        count_in = CW'(count_ff + 1'b1);
                        ram_we   = 1'b1;
                        if (req_payload.func == FN_PUSH_FRONT) begin
                           head_in   = head_dec;
                           ram_waddr = head_dec;
                           front_in  = req_payload.value;
                           if (empty) begin
                              back_in = req_payload.value;
                           end
                        end else begin
                           tail_in   = tail_inc;
                           ram_waddr = tail_inc;
                           back_in   = req_payload.value;
                           if (empty) begin
                              front_in = req_payload.value;
                           end
                        end
                     end
                  end
                  FN_POP_FRONT, FN_POP_BACK: begin
                     if (empty) begin
                        under = 1'b1;
                     end else begin
                        count_in = CW'(count_ff - 1'b1);
                        if (req_payload.func == FN_POP_FRONT) begin
                           popped    = front_ff;
                           head_in   = head_inc;
                           ram_raddr = head_inc;
                        end else begin
                           popped    = back_ff;
                           tail_in   = tail_dec;
                           ram_raddr = tail_dec;
                        end
                        // With one or more left, the new end element must come from storage.
                        if (count_ff != CW'(1)) begin
                           ram_re         = 1'b1;
                           load_now       = 1'b0;
                           state_in       = DQ_READ;
                           pend_front_in  = (req_payload.func == FN_POP_FRONT);
                           pend_popped_in = popped;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         DQ_READ: begin
            load_now = 1'b1;
            popped   = pend_popped_ff;
            state_in = DQ_IDLE;
            if (pend_front_ff) begin
               front_in = ram_rdata;
            end else begin
               back_in = ram_rdata;
            end
         end
         default: begin
            state_in = DQ_IDLE;
         end
      endcase

      load.load             = load_now;
      load.rsp.popped_value = popped;
      load.rsp.underflow    = under;
      load.rsp.overflow     = over;
      load.rsp.front_value  = (count_in == '0) ? EMPTY_VALUE : front_in;
      load.rsp.back_value   = (count_in == '0) ? EMPTY_VALUE : back_in;
      load.rsp.occupancy    = OCC_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DQ_IDLE;
         head_ff  <= '0;
         tail_ff  <= LAST_IDX;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      front_ff       <= front_in;
      back_ff        <= back_in;
      pend_front_ff  <= pend_front_in;
      pend_popped_ff <= pend_popped_in;
   end

endmodule

`default_nettype wire

/* rtl/double_ended_queue.sv */
// Push, push on full, query, pop on empty and a pop that empties the queue register their result
// as the transaction is accepted; a pop that leaves one or more elements first reads the new
// end element from the slot RAM, and its result is registered from the read state.
// Throughput: one transaction per cycle while the output is free; none is taken during such a read.
// Reset clears state, head, count and output valid, sets the back index to the last slot; slot RAM is not cleared.
`default_nettype none

module double_ended_queue #(
   parameter int DEPTH = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire dq_pkg::dq_req_type req_payload,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output dq_pkg::dq_rsp_type      rsp_payload
);

   import dq_pkg::*;

   localparam int IW = $clog2(DEPTH);

   dq_load_type       load;
   logic              out_free;
   logic              ram_we, ram_re;
   logic [IW-1:0]     ram_waddr, ram_raddr;
   logic [DATA_W-1:0] ram_wdata, ram_rdata;

   logic              rsp_valid_ff, rsp_valid_in;
   dq_rsp_type        rsp_payload_ff, rsp_payload_in;

   assign out_free = !rsp_valid_ff || rsp_ready;

   dq_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .out_free   (out_free),
      .load       (load),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .ram_re     (ram_re),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata)
   );

   dq_ram #(
      .WIDTH(DATA_W),
      .DEPTH(DEPTH)
   ) u_slots (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (load.load) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = load.rsp;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

/* verif/dq_checker.sv */
`timescale 1ns / 1ps

module dq_checker #(
   parameter int DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  dq_pkg::dq_req_type    req_payload,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  dq_pkg::dq_rsp_type    rsp_payload,
   output int                    error_count,
   output int                    pending_count
);
   import dq_pkg::*;

   localparam int AWAIT_DEPTH = 64;

   // Shadow copy of the circular store, kept in step with accepted requests.
   logic signed [DATA_W-1:0] shadow_slots [DEPTH];
   int                       shadow_head;
   int                       shadow_count;

   // Expected responses in order, held in a ring.
   dq_rsp_type               awaited_rsp [AWAIT_DEPTH];
   int                       await_rd;
   int                       await_wr;
   int                       await_count;

   function automatic void shadow_apply(input dq_req_type req, output dq_rsp_type rsp);
      rsp = '0;
      rsp.front_value = EMPTY_VALUE;
      rsp.back_value  = EMPTY_VALUE;
      case (req.func)
         FN_PUSH_FRONT, FN_PUSH_BACK: begin
            if (shadow_count >= DEPTH) begin
               rsp.overflow = 1'b1;
            end else if (req.func == FN_PUSH_FRONT) begin
               shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
               shadow_slots[shadow_head] = req.value;
               shadow_count++;
            end else begin
               shadow_slots[(shadow_head + shadow_count) % DEPTH] = req.value;
               shadow_count++;
            end
         end
         FN_POP_FRONT, FN_POP_BACK: begin
            if (shadow_count == 0) begin
               rsp.underflow = 1'b1;
            end else if (req.func == FN_POP_FRONT) begin
               rsp.popped_value = shadow_slots[shadow_head];
               shadow_head = (shadow_head + 1) % DEPTH;
               shadow_count--;
            end else begin
               rsp.popped_value = shadow_slots[(shadow_head + shadow_count - 1) % DEPTH];
               shadow_count--;
            end
         end
         default: ;
      endcase
      if (shadow_count != 0) begin
         rsp.front_value = shadow_slots[shadow_head];
         rsp.back_value  = shadow_slots[(shadow_head + shadow_count - 1) % DEPTH];
      end
      rsp.occupancy = OCC_W'(shadow_count);
   endfunction

   function automatic void compare_field(input string name, input logic signed [63:0] want,
                                         input logic signed [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin : watch
      dq_rsp_type want;
      if (reset) begin
         shadow_head  = 0;
         shadow_count = 0;
         await_rd     = 0;
         await_wr     = 0;
         await_count  = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (await_count == 0) begin
               $error("response transaction with no request waiting for it");
               error_count++;
            end else begin
               want = awaited_rsp[await_rd];
               await_rd = (await_rd + 1) % AWAIT_DEPTH;
               await_count--;
               compare_field("popped_value", want.popped_value, rsp_payload.popped_value);
               compare_field("underflow", want.underflow, rsp_payload.underflow);
               compare_field("overflow", want.overflow, rsp_payload.overflow);
               compare_field("front_value", want.front_value, rsp_payload.front_value);
               compare_field("back_value", want.back_value, rsp_payload.back_value);
               compare_field("occupancy", want.occupancy, rsp_payload.occupancy);
            end
         end
         if (req_valid && req_ready) begin
            shadow_apply(req_payload, want);
            if (await_count >= AWAIT_DEPTH) begin
               $error("more request transactions outstanding than the checker can hold");
               error_count++;
            end else begin
               awaited_rsp[await_wr] = want;
               await_wr = (await_wr + 1) % AWAIT_DEPTH;
               await_count++;
            end
         end
      end
      pending_count = await_count;
   end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
   import dq_pkg::*;

   localparam int DEPTH       = 16;
   localparam int HOLD_CYCLES = 80;
   localparam int SEGMENTS    = 15;
   localparam int SEGMENT_LEN = 50;

   // Code 4 is a plain query; 5 to 7 are unused and must behave the same way.
   localparam logic [FUNC_W-1:0] FN_QUERY = 3'd4;

   localparam logic signed [DATA_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] VALUE_MIN = 32'sh8000_0000;

   typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_type;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic       rsp_ready = 1'b0;
   dq_req_type req_payload = '0;
   logic       req_ready;
   logic       rsp_valid;
   dq_rsp_type rsp_payload;

   int         error_count;
   int         pending_count;
   bit         no_idle  = 1'b0;
   bit         hold_rsp = 1'b0;

   always #5 clock = ~clock;

   double_ended_queue #(
      .DEPTH(DEPTH)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload)
   );

   dq_checker #(
      .DEPTH(DEPTH)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .error_count(error_count),
      .pending_count(pending_count)
   );

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(15))
         0: return VALUE_MAX;
         1: return VALUE_MIN;
         2: return '0;
         3: return EMPTY_VALUE;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [FUNC_W-1:0] pick_func(input mix_type mix);
      int push_pct;
      push_pct = (mix == MIX_FILL) ? 75 : (mix == MIX_DRAIN) ? 25 : 50;
      if ($urandom_range(99) < 6) return FN_QUERY + FUNC_W'($urandom_range(3));
      if ($urandom_range(99) < push_pct) return $urandom_range(1) ? FN_PUSH_BACK : FN_PUSH_FRONT;
      return $urandom_range(1) ? FN_POP_BACK : FN_POP_FRONT;
   endfunction

   task automatic send_request(input logic [FUNC_W-1:0] func,
                               input logic signed [DATA_W-1:0] value);
      if (!no_idle && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{func: func, value: value};
      do @(posedge clock); while (!req_ready);
   endtask

   // Stops offering and waits until every response has been returned.
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin : receiver
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= no_idle || ($urandom_range(99) >= 8);
      end
   end

   initial begin : stimulus
      mix_type mix;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_request(FN_POP_FRONT, pick_value());
      send_request(FN_POP_BACK, pick_value());
      send_request(FN_QUERY, pick_value());
      send_request(FN_PUSH_BACK, VALUE_MAX);
      send_request(FN_PUSH_FRONT, VALUE_MIN);
      send_request(FN_PUSH_BACK, '0);
      send_request(FN_PUSH_FRONT, EMPTY_VALUE);
      send_request(FN_QUERY, pick_value());
      send_request(FN_QUERY + 3'd1, pick_value());
      send_request(FN_QUERY + 3'd2, pick_value());
      send_request(FN_QUERY + 3'd3, pick_value());
      send_request(FN_POP_BACK, pick_value());
      send_request(FN_POP_FRONT, pick_value());
      send_request(FN_POP_BACK, pick_value());
      send_request(FN_POP_FRONT, pick_value());
      send_request(FN_POP_FRONT, pick_value());
      drain_responses();

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         mix = mix_type'(seg % 3);
         no_idle = (seg == 4);
         if (seg == 7) hold_rsp = 1'b1;
         for (int i = 0; i < SEGMENT_LEN; i++) begin
            send_request(pick_func(mix), pick_value());
         end
         no_idle = 1'b0;
         if (seg % 4 == 3) drain_responses();
      end

      drain_responses();
      repeat (16) @(posedge clock);
      if (error_count == 0) begin
         $display("[double_ended_queue] OK");
      end else begin
         $display("[double_ended_queue] ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("[double_ended_queue] ERROR");
      $finish;
   end

endmodule
